>>> design/weighted_vtime_accounting_macros.svh
// assertion helpers for the checker of this block
`ifndef WEIGHTED_VTIME_ACCOUNTING_MACROS_SVH
`define WEIGHTED_VTIME_ACCOUNTING_MACROS_SVH

// same-cycle implication
`define WVA_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define WVA_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/wva_pkg.sv
package wva_pkg;

    localparam int VT_W     = 64;
    localparam int SLICE_W  = 32;
    localparam int W_W      = 14;
    localparam int FACT_W   = 8;
    localparam int L0_W     = 16;
    localparam int SCALE_W  = 7;
    localparam int NUM_W    = SLICE_W + SCALE_W;
    localparam int DEN_W    = FACT_W + W_W;
    localparam int DCNT_W   = 6;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 32;

    localparam logic [SCALE_W-1:0] CHARGE_SCALE = 7'd100;

    localparam logic [FACT_W-1:0]  RST_THRESHOLD = 8'd10;
    localparam logic [FACT_W-1:0]  RST_BOOST     = 8'd8;
    localparam logic [FACT_W-1:0]  RST_BASE      = 8'd2;
    localparam logic [SLICE_W-1:0] RST_SLICE     = 32'd20000000;

    typedef enum logic [1:0] {
        ACT_ENABLE  = 2'd0,
        ACT_ENQUEUE = 2'd1,
        ACT_RUNNING = 2'd2,
        ACT_STOPPING = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        CLS_ORDINARY = 2'd0,
        CLS_COMPACT  = 2'd1,
        CLS_FLUSH    = 2'd2
    } t_class;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FIFO_MODE     = 3'd0,
        REG_LEVEL_THRESH  = 3'd1,
        REG_BOOST_FACTOR  = 3'd2,
        REG_BASE_FACTOR   = 3'd3,
        REG_DEFAULT_SLICE = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic capture;
        logic prep;
        logic mult;
        logic div_step;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic need_div;
    } t_sts;

endpackage

>>> design/weighted_vtime_accounting.sv
// Virtual-time unit for a weighted fair scheduler: one result beat per event beat.
// Enable, enqueue and running beats pass through the prep, mult and finish states after
// capture; a stopping beat (outside fifo mode) also runs the 39-step restoring divider
// that forms used_slice*100 / (factor*weight) one quotient bit per cycle, before finish.
// One event is worked at a time; the next input beat is taken as soon as the previous
// result sits in the output register, even while the output is stalled. The user must
// write registers through the plain write port only while no event is in flight; the
// block itself does not enforce it.
module weighted_vtime_accounting (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [wva_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wva_pkg::CFG_DAT_W-1:0]       i_cfg_wdata,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic [1:0]                          i_action,
    input  logic [wva_pkg::VT_W-1:0]            i_task_vtime,
    input  logic [wva_pkg::SLICE_W-1:0]         i_slice_left,
    input  logic [wva_pkg::W_W-1:0]             i_task_weight,
    input  logic [1:0]                          i_task_class,
    input  logic [wva_pkg::L0_W-1:0]            i_level0_count,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [wva_pkg::VT_W-1:0]            o_vtime_out,
    output logic                                o_vtime_ordered,
    output logic [wva_pkg::VT_W-1:0]            o_enqueue_total
);
    import wva_pkg::*;

    t_cmd cmd;
    t_sts sts;

    wva_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    wva_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_action        (i_action),
        .i_task_vtime    (i_task_vtime),
        .i_slice_left    (i_slice_left),
        .i_task_weight   (i_task_weight),
        .i_task_class    (i_task_class),
        .i_level0_count  (i_level0_count),
        .o_vtime_out     (o_vtime_out),
        .o_vtime_ordered (o_vtime_ordered),
        .o_enqueue_total (o_enqueue_total)
    );

endmodule

>>> design/wva_ctrl.sv
module wva_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    input  wva_pkg::t_sts i_sts,
    output wva_pkg::t_cmd o_cmd
);
    import wva_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_PREP = 5'b00010,
        S_MULT = 5'b00100,
        S_DIV  = 5'b01000,
        S_FIN  = 5'b10000
    } t_state;

    t_state             r_state, n_state;
    logic [DCNT_W-1:0]  r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic               out_free;

    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                o_cmd.prep = 1'b1;
                n_state = S_MULT;
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_cnt = DCNT_W'(NUM_W - 1);
                n_state = i_sts.need_div ? S_DIV : S_FIN;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt = r_cnt - DCNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                // hold the result until the output register is free
                if (out_free) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.finish) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> design/wva_dp.sv
module wva_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  wva_pkg::t_cmd                       i_cmd,
    output wva_pkg::t_sts                       o_sts,
    input  logic                                i_cfg_we,
    input  logic [wva_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [wva_pkg::CFG_DAT_W-1:0]       i_cfg_wdata,
    input  logic [1:0]                          i_action,
    input  logic [wva_pkg::VT_W-1:0]            i_task_vtime,
    input  logic [wva_pkg::SLICE_W-1:0]         i_slice_left,
    input  logic [wva_pkg::W_W-1:0]             i_task_weight,
    input  logic [1:0]                          i_task_class,
    input  logic [wva_pkg::L0_W-1:0]            i_level0_count,
    output logic [wva_pkg::VT_W-1:0]            o_vtime_out,
    output logic                                o_vtime_ordered,
    output logic [wva_pkg::VT_W-1:0]            o_enqueue_total
);
    import wva_pkg::*;

    // configuration
    logic               r_fifo;
    logic [FACT_W-1:0]  r_thresh;
    logic [FACT_W-1:0]  r_boost;
    logic [FACT_W-1:0]  r_base;
    logic [SLICE_W-1:0] r_slice;

    // state
    logic [VT_W-1:0]    r_cur, n_cur;
    logic [VT_W-1:0]    r_enq, n_enq;

    // captured beat
    logic [1:0]         r_action;
    logic [VT_W-1:0]    r_tv;
    logic [SLICE_W-1:0] r_left;
    logic [W_W-1:0]     r_weight;
    logic [1:0]         r_cls;
    logic [L0_W-1:0]    r_l0;

    // working registers
    logic [SLICE_W-1:0] r_used;
    logic [FACT_W-1:0]  r_factor;
    logic [VT_W-1:0]    r_floor;
    logic               r_before;
    logic [NUM_W-1:0]   r_num;
    logic [DEN_W-1:0]   r_den;
    logic [DEN_W-1:0]   r_rem;

    logic [VT_W-1:0]    r_vout;
    logic               r_ordered;
    logic [VT_W-1:0]    r_total;

    logic               over;
    logic [FACT_W-1:0]  fac_sel;
    logic [NUM_W-1:0]   prod_num;
    logic [DEN_W-1:0]   prod_den;
    logic [VT_W-1:0]    diff;
    logic [DEN_W:0]     rem_sh;
    logic               rem_ge;
    logic [DEN_W:0]     rem_sub;
    logic [VT_W-1:0]    n_vout;
    logic               is_enq;
    logic               fifo_off;

    assign fifo_off = !r_fifo;
    assign is_enq   = (r_action == ACT_ENQUEUE);
    assign o_sts.need_div = (r_action == ACT_STOPPING) && fifo_off;

    assign over = r_l0 > {{(L0_W-FACT_W){1'b0}}, r_thresh};

    always_comb begin
        case (r_cls)
            CLS_COMPACT: fac_sel = over ? r_boost : r_base;
            CLS_FLUSH:   fac_sel = over ? r_base : r_boost;
            default:     fac_sel = FACT_W'(1);
        endcase
        if (fac_sel == '0) begin
            fac_sel = FACT_W'(1);
        end
    end

    assign prod_num = {{(NUM_W-SLICE_W){1'b0}}, r_used}
                    * {{(NUM_W-SCALE_W){1'b0}}, CHARGE_SCALE};
    assign prod_den = {{W_W{1'b0}}, r_factor} * {{FACT_W{1'b0}}, r_weight};

    // wrap-safe compare: sign of the difference
    assign diff = is_enq ? (r_tv - r_floor) : (r_cur - r_tv);

    // restoring divide, one quotient bit per step
    assign rem_sh  = {r_rem, r_num[NUM_W-1]};
    assign rem_ge  = rem_sh >= {1'b0, r_den};
    assign rem_sub = rem_sh - {1'b0, r_den};

    always_comb begin
        n_cur  = r_cur;
        n_enq  = r_enq;
        n_vout = r_tv;
        case (r_action)
            ACT_ENABLE: begin
                n_vout = r_cur;
            end
            ACT_ENQUEUE: begin
                n_enq = r_enq + VT_W'(1);
                if (fifo_off && r_before) begin
                    n_vout = r_floor;
                end
            end
            ACT_RUNNING: begin
                if (fifo_off && r_before) begin
                    n_cur = r_tv;
                end
            end
            ACT_STOPPING: begin
                if (fifo_off) begin
                    n_vout = r_tv + {{(VT_W-NUM_W){1'b0}}, r_num};
                end
            end
            default: begin
                n_vout = r_tv;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fifo   <= 1'b0;
            r_thresh <= RST_THRESHOLD;
            r_boost  <= RST_BOOST;
            r_base   <= RST_BASE;
            r_slice  <= RST_SLICE;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FIFO_MODE:     r_fifo   <= i_cfg_wdata[0];
                REG_LEVEL_THRESH:  r_thresh <= i_cfg_wdata[FACT_W-1:0];
                REG_BOOST_FACTOR:  r_boost  <= i_cfg_wdata[FACT_W-1:0];
                REG_BASE_FACTOR:   r_base   <= i_cfg_wdata[FACT_W-1:0];
                REG_DEFAULT_SLICE: r_slice  <= i_cfg_wdata[SLICE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur <= '0;
            r_enq <= '0;
        end else if (i_cmd.finish) begin
            r_cur <= n_cur;
            r_enq <= n_enq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_action <= i_action;
            r_tv     <= i_task_vtime;
            r_left   <= i_slice_left;
            r_weight <= (i_task_weight == '0) ? W_W'(1) : i_task_weight;
            r_cls    <= i_task_class;
            r_l0     <= i_level0_count;
        end
        if (i_cmd.prep) begin
            r_used   <= (r_slice > r_left) ? (r_slice - r_left) : '0;
            r_factor <= fac_sel;
            r_floor  <= r_cur - {{(VT_W-SLICE_W){1'b0}}, r_slice};
        end
        if (i_cmd.mult) begin
            r_num    <= prod_num;
            r_den    <= prod_den;
            r_rem    <= '0;
            r_before <= diff[VT_W-1];
        end
        if (i_cmd.div_step) begin
            if (rem_ge) begin
                r_rem <= rem_sub[DEN_W-1:0];
                r_num <= {r_num[NUM_W-2:0], 1'b1};
            end else begin
                r_rem <= rem_sh[DEN_W-1:0];
                r_num <= {r_num[NUM_W-2:0], 1'b0};
            end
        end
        if (i_cmd.finish) begin
            r_vout    <= n_vout;
            r_ordered <= is_enq && fifo_off;
            r_total   <= n_enq;
        end
    end

    assign o_vtime_out     = r_vout;
    assign o_vtime_ordered = r_ordered;
    assign o_enqueue_total = r_total;

endmodule

>>> design/wva_checker.sv
`include "weighted_vtime_accounting_macros.svh"

module wva_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                o_in_stall,
    input  logic                                o_out_valid,
    input  logic                                i_out_stall,
    input  logic [wva_pkg::VT_W-1:0]            o_vtime_out,
    input  logic                                o_vtime_ordered,
    input  logic [wva_pkg::VT_W-1:0]            o_enqueue_total
);
    import wva_pkg::*;

    logic in_beat;
    assign in_beat = i_in_valid && !o_in_stall;

    // one event in flight: busy right after an input beat
    `WVA_ASSERT_NXT(a_busy_after_beat, i_clk, i_rst_n, in_beat, o_in_stall, "not busy after input beat")

    // a result never shows up the cycle after an input beat
    `WVA_ASSERT_NXT(a_min_latency, i_clk, i_rst_n, in_beat, !$rose(o_out_valid), "result too early")

    // a new result is only loaded while an event was being worked
    `WVA_ASSERT_IMP(a_result_from_work, i_clk, i_rst_n, $rose(o_out_valid), $past(o_in_stall), "result without work")

    // stalled result beat holds
    `WVA_ASSERT_NXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall, o_out_valid && $stable(o_vtime_out) && $stable(o_enqueue_total) && $stable(o_vtime_ordered), "stalled result changed")

endmodule

bind weighted_vtime_accounting wva_checker u_wva_checker (.*);

>>> verif/weighted_vtime_accounting_test.sv
`timescale 1ns / 100ps

module weighted_vtime_accounting_test;
    import wva_pkg::*;

    localparam int          CYCLE_LIMIT = 400000;
    localparam logic [1:0]  CLS_UNUSED  = 2'd3;
    localparam logic [63:0] VT_ONES     = '1;
    localparam logic [63:0] VT_HALF     = 64'h8000_0000_0000_0000;

    typedef struct {
        logic [63:0] vtime;
        logic        ordered;
        logic [63:0] total;
    } t_vt_result;

    // keeps its own copy of the vtime state and registers, predicts each result beat
    class vtime_ledger;
        logic [63:0] now_vt;
        logic [63:0] enq_seen;
        logic        fifo_on;
        logic [7:0]  thresh;
        logic [7:0]  boost;
        logic [7:0]  base;
        logic [31:0] slice_ns;
        logic [63:0] last_vtime;
        t_vt_result  pending_results[$];
        int          mismatches;
        int          checked;
        int          act_seen[4];

        function new();
            now_vt     = '0;
            enq_seen   = '0;
            fifo_on    = 1'b0;
            thresh     = RST_THRESHOLD;
            boost      = RST_BOOST;
            base       = RST_BASE;
            slice_ns   = RST_SLICE;
            last_vtime = '0;
            mismatches = 0;
            checked    = 0;
            foreach (act_seen[i]) act_seen[i] = 0;
        endfunction

        function void cfg_write(t_reg_idx idx, logic [31:0] v);
            case (idx)
                REG_FIFO_MODE:     fifo_on  = v[0];
                REG_LEVEL_THRESH:  thresh   = v[7:0];
                REG_BOOST_FACTOR:  boost    = v[7:0];
                REG_BASE_FACTOR:   base     = v[7:0];
                REG_DEFAULT_SLICE: slice_ns = v;
                default: ;
            endcase
        endfunction

        // wrap-safe: a is before b when the difference is negative
        function logic vt_before(logic [63:0] a, logic [63:0] b);
            logic [63:0] diff;
            diff = a - b;
            return diff[63];
        endfunction

        function void note_event(logic [1:0] act, logic [63:0] tv, logic [31:0] left,
                                 logic [13:0] w, logic [1:0] cls, logic [15:0] l0);
            t_vt_result  r;
            logic [63:0] floor_v;
            logic [63:0] used;
            logic [63:0] fac;
            logic [63:0] wt;
            logic        over;
            r.vtime   = tv;
            r.ordered = 1'b0;
            act_seen[act]++;
            case (act)
                ACT_ENABLE: begin
                    r.vtime = now_vt;
                end
                ACT_ENQUEUE: begin
                    enq_seen = enq_seen + 64'd1;
                    if (!fifo_on) begin
                        floor_v = now_vt - {32'd0, slice_ns};
                        if (vt_before(tv, floor_v))
                            r.vtime = floor_v;
                        r.ordered = 1'b1;
                    end
                end
                ACT_RUNNING: begin
                    if (!fifo_on && vt_before(now_vt, tv))
                        now_vt = tv;
                end
                default: begin
                    if (!fifo_on) begin
                        used = (slice_ns > left) ? {32'd0, slice_ns} - {32'd0, left} : 64'd0;
                        over = l0 > {8'd0, thresh};
                        wt   = (w == '0) ? 64'd1 : {50'd0, w};
                        if (cls == CLS_COMPACT)
                            fac = over ? {56'd0, boost} : {56'd0, base};
                        else if (cls == CLS_FLUSH)
                            fac = over ? {56'd0, base} : {56'd0, boost};
                        else
                            fac = 64'd1;
                        if (fac == 64'd0)
                            fac = 64'd1;
                        r.vtime = tv + (used * 64'd100) / (fac * wt);
                    end
                end
            endcase
            r.total    = enq_seen;
            last_vtime = r.vtime;
            pending_results.push_back(r);
        endfunction

        function void check_beat(logic [63:0] vt, logic ord, logic [63:0] tot);
            t_vt_result want;
            if (pending_results.size() == 0) begin
                $error("result beat with nothing pending: vtime_out %h", vt);
                mismatches++;
                return;
            end
            want = pending_results.pop_front();
            checked++;
            if (vt !== want.vtime) begin
                $error("vtime_out: expected %h, got %h", want.vtime, vt);
                mismatches++;
            end
            if (ord !== want.ordered) begin
                $error("vtime_ordered: expected %b, got %b", want.ordered, ord);
                mismatches++;
            end
            if (tot !== want.total) begin
                $error("enqueue_total: expected %h, got %h", want.total, tot);
                mismatches++;
            end
        endfunction
    endclass

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = '0;
    logic [CFG_DAT_W-1:0]  i_cfg_wdata     = '0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_stall;
    logic [1:0]            i_action        = '0;
    logic [VT_W-1:0]       i_task_vtime    = '0;
    logic [SLICE_W-1:0]    i_slice_left    = '0;
    logic [W_W-1:0]        i_task_weight   = '0;
    logic [1:0]            i_task_class    = '0;
    logic [L0_W-1:0]       i_level0_count  = '0;
    logic                  o_out_valid;
    logic                  i_out_stall     = 1'b0;
    logic [VT_W-1:0]       o_vtime_out;
    logic                  o_vtime_ordered;
    logic [VT_W-1:0]       o_enqueue_total;

    vtime_ledger ledger;
    bit          calm = 1'b0;
    int          cycles = 0;
    int          settings_used = 0;

    weighted_vtime_accounting u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_action        (i_action),
        .i_task_vtime    (i_task_vtime),
        .i_slice_left    (i_slice_left),
        .i_task_weight   (i_task_weight),
        .i_task_class    (i_task_class),
        .i_level0_count  (i_level0_count),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_vtime_out     (o_vtime_out),
        .o_vtime_ordered (o_vtime_ordered),
        .o_enqueue_total (o_enqueue_total)
    );

    always #4 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("weighted_vtime_accounting regression: fail");
            $finish;
        end
    end

    // result side: check accepted beats, stall at random
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            ledger.check_beat(o_vtime_out, o_vtime_ordered, o_enqueue_total);
        i_out_stall <= !calm && ($urandom_range(99) < 13);
    end

    task automatic send(logic [1:0] act, logic [63:0] tv, logic [31:0] left,
                        logic [13:0] w, logic [1:0] cls, logic [15:0] l0);
        if (!calm && $urandom_range(99) < 13) begin
            i_in_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < 13);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_task_vtime   <= tv;
        i_slice_left   <= left;
        i_task_weight  <= w;
        i_task_class   <= cls;
        i_level0_count <= l0;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        ledger.note_event(act, tv, left, w, cls, l0);
    endtask

    // wait for every pending result, then let the block sit quiet
    task automatic settle();
        i_in_valid <= 1'b0;
        while (ledger.pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic put_reg(t_reg_idx idx, logic [31:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        ledger.cfg_write(idx, v);
    endtask

    task automatic apply_settings(logic fifo, logic [7:0] th, logic [7:0] bo,
                                  logic [7:0] ba, logic [31:0] sl);
        put_reg(REG_FIFO_MODE, {31'd0, fifo});
        put_reg(REG_LEVEL_THRESH, {24'd0, th});
        put_reg(REG_BOOST_FACTOR, {24'd0, bo});
        put_reg(REG_BASE_FACTOR, {24'd0, ba});
        put_reg(REG_DEFAULT_SLICE, sl);
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    initial begin
        logic [63:0] pool_vt[4];
        t_action     pool_next[4];
        t_action     act;
        logic [31:0] left;
        logic [13:0] w;
        logic [1:0]  cls;
        logic [15:0] l0;
        logic        fifo;
        logic [7:0]  th;
        logic [7:0]  bo;
        logic [7:0]  ba;
        logic [31:0] sl;
        int          k;

        ledger = new();
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: wrapping floor, clamp, wrap-safe running, all charge paths
        send(ACT_ENABLE, VT_ONES, '0, 14'd100, CLS_ORDINARY, '0);
        send(ACT_ENQUEUE, '0, '0, 14'd100, CLS_ORDINARY, '0);
        send(ACT_RUNNING, 64'd50_000_000, '0, 14'd100, CLS_ORDINARY, '0);
        send(ACT_ENQUEUE, '0, '0, 14'd100, CLS_ORDINARY, '0);
        send(ACT_RUNNING, VT_ONES, '0, 14'd100, CLS_ORDINARY, '0);
        send(ACT_RUNNING, VT_HALF, '0, 14'd100, CLS_ORDINARY, '0);
        send(ACT_ENABLE, '0, '1, '1, CLS_UNUSED, '1);
        send(ACT_ENQUEUE, VT_ONES, '0, 14'd100, CLS_ORDINARY, '0);
        send(ACT_STOPPING, '0, '0, 14'd1, CLS_ORDINARY, '0);
        send(ACT_STOPPING, VT_ONES, '1, 14'd10000, CLS_COMPACT, '0);
        send(ACT_STOPPING, VT_ONES, '0, 14'd100, CLS_COMPACT, 16'd11);
        send(ACT_STOPPING, 64'd12345, 32'd19_999_999, '0, CLS_FLUSH, 16'd10);
        send(ACT_STOPPING, VT_HALF, '0, 14'd10000, CLS_FLUSH, '1);
        send(ACT_STOPPING, 64'd7, 32'd1000, 14'd3, CLS_UNUSED, 16'd500);
        send(ACT_ENABLE, '0, '0, 14'd100, CLS_ORDINARY, '0);
        settle();

        // fifo mode: vtimes pass through, enable still reports current
        apply_settings(1'b1, RST_THRESHOLD, RST_BOOST, RST_BASE, RST_SLICE);
        send(ACT_ENABLE, 64'd99, '0, 14'd100, CLS_ORDINARY, '0);
        send(ACT_ENQUEUE, '0, '0, 14'd100, CLS_ORDINARY, '0);
        send(ACT_RUNNING, VT_ONES - 64'd5, '0, 14'd100, CLS_ORDINARY, '0);
        send(ACT_STOPPING, 64'd42, '0, 14'd1, CLS_COMPACT, '0);
        settle();

        // zero factor read as one, widest slice, top threshold
        apply_settings(1'b0, 8'd255, 8'd0, 8'd255, '1);
        send(ACT_STOPPING, '0, '0, 14'd1, CLS_COMPACT, '1);
        send(ACT_STOPPING, 64'd5, '0, 14'd1, CLS_FLUSH, '0);
        send(ACT_ENQUEUE, '0, '0, 14'd100, CLS_ORDINARY, '0);
        settle();

        apply_settings(1'b0, 8'd0, 8'd255, 8'd1, 32'd1);
        send(ACT_STOPPING, 64'd100, '0, 14'd1, CLS_COMPACT, 16'd1);
        send(ACT_ENQUEUE, '0, '0, 14'd100, CLS_ORDINARY, '0);

        for (int p = 0; p < 8; p++) begin
            settle();
            fifo = ($urandom_range(3) == 0);
            case ($urandom_range(3))
                0: th = 8'd0;
                1: th = 8'd255;
                default: th = 8'($urandom_range(255));
            endcase
            case ($urandom_range(3))
                0: bo = 8'd1;
                1: bo = 8'd255;
                default: bo = 8'($urandom_range(255, 1));
            endcase
            case ($urandom_range(3))
                0: ba = 8'd1;
                1: ba = 8'd255;
                default: ba = 8'($urandom_range(255, 1));
            endcase
            case ($urandom_range(4))
                0: sl = 32'd1;
                1: sl = '1;
                2: sl = $urandom_range(1000, 1);
                3: sl = $urandom | 32'd1;
                default: sl = RST_SLICE;
            endcase
            if (p == 0) begin
                fifo = 1'b0;
                sl   = RST_SLICE;
            end
            apply_settings(fifo, th, bo, ba, sl);
            calm = (p == 3);
            foreach (pool_next[i]) begin
                pool_next[i] = ACT_ENABLE;
                pool_vt[i]   = '0;
            end

            for (int n = 0; n < 50; n++) begin
                k = $urandom_range(3);
                case ($urandom_range(7))
                    0: left = '0;
                    1: left = $urandom;
                    default: left = $urandom_range(ledger.slice_ns);
                endcase
                w   = ($urandom_range(5) == 0) ? 14'd100 : 14'($urandom_range(10000, 1));
                cls = ($urandom_range(9) == 0) ? CLS_UNUSED : 2'($urandom_range(2));
                if ($urandom_range(3) == 0) begin
                    l0 = 16'($urandom);
                end else begin
                    // hover around the threshold so both factor choices show up
                    l0 = {8'd0, ledger.thresh} + 16'($urandom_range(2));
                    if (l0 != '0)
                        l0 = l0 - 16'd1;
                end
                if ($urandom_range(99) < 15) begin
                    send(2'($urandom_range(3)), {$urandom, $urandom}, $urandom,
                         14'($urandom_range(10000, 1)), 2'($urandom_range(3)),
                         16'($urandom));
                end else begin
                    // one task walking through its lifecycle
                    act = pool_next[k];
                    send(act, (act == ACT_ENABLE) ? {$urandom, $urandom} : pool_vt[k],
                         left, w, cls, l0);
                    pool_vt[k] = ledger.last_vtime;
                    case (act)
                        ACT_ENABLE:  pool_next[k] = ACT_ENQUEUE;
                        ACT_ENQUEUE: pool_next[k] = ACT_RUNNING;
                        ACT_RUNNING: pool_next[k] = ACT_STOPPING;
                        default:     pool_next[k] = ACT_ENQUEUE;
                    endcase
                end
            end
            calm = 1'b0;
        end

        settle();
        repeat (50) @(posedge i_clk);
        $display("run covered %0d enable, %0d enqueue, %0d running, %0d stopping beats",
                 ledger.act_seen[ACT_ENABLE], ledger.act_seen[ACT_ENQUEUE],
                 ledger.act_seen[ACT_RUNNING], ledger.act_seen[ACT_STOPPING]);
        $display("%0d result beats compared over %0d register settings, %0d mismatches",
                 ledger.checked, settings_used + 1, ledger.mismatches);
        if (ledger.mismatches == 0)
            $display("weighted_vtime_accounting regression: pass");
        else
            $display("weighted_vtime_accounting regression: fail");
        $finish;
    end

endmodule
